>>> rtl/core/scfr_pkg.sv
package scfr_pkg;

    // sync pair that opens every frame
    localparam logic [7:0] SYNC_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;

    // frame position: hunting, or index of the next frame byte expected
    typedef enum logic [2:0] {
        POS_HUNT    = 3'd0,
        POS_CMD_HI  = 3'd2,
        POS_CMD_LO  = 3'd3,
        POS_CSUM_HI = 3'd4,
        POS_CSUM_LO = 3'd5
    } t_frame_pos;

    // registered input beat handed to the deframer
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_byte_beat;

    // result beat handed to the output register
    typedef struct packed {
        logic        valid;
        logic [15:0] command;
    } t_cmd_beat;

endpackage

>>> rtl/core/scfr_if.sv
// received byte channel
interface scfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// decoded command channel
interface scfr_cmd_if;
    logic        valid;
    logic        ready;
    logic [15:0] command;

    modport source (output valid, output command, input ready);
    modport sink   (input valid, input command, output ready);
endinterface

>>> rtl/core/sync_checksum_frame_receiver.sv
// Frame receiver for a byte stream with a two-byte sync and additive checksum.
// i_rx carries one received byte per beat; o_cmd carries one 16-bit command
// per good frame. A frame is 0xA5 0x5A, command high, command low, checksum
// high, checksum low; the checksum is the 16-bit sum of the first four bytes.
// Frames with a bad checksum give no beat on o_cmd.
// Throughput: one byte per cycle while o_cmd does not stall; the deframer
// decodes each byte combinationally between the input register and the command register.
// Path: a byte taken into the input register is decoded by the deframer from
// that register; a command from the last checksum byte is then registered in
// the command register, which offers it on o_cmd.
// Reset (synchronous, active low) empties both registers, returns the
// deframer to hunting and clears the remembered previous byte.
// When o_cmd stalls with a command held, the deframer stops and i_rx.ready
// drops once the input register is full; no byte or command is lost.
module sync_checksum_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scfr_byte_if.sink   i_rx,
    scfr_cmd_if.source  o_cmd
);

    scfr_pkg::t_byte_beat beat;
    scfr_pkg::t_cmd_beat  res;
    logic                 take;
    logic                 out_free;

    // input register
    scfr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_beat  (beat)
    );

    // frame tracking and checksum compare
    scfr_deframer u_deframer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (beat),
        .i_out_free (out_free),
        .o_take     (take),
        .o_res      (res)
    );

    // command register
    scfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_free  (out_free),
        .o_cmd   (o_cmd)
    );

endmodule

>>> rtl/core/scfr_in_stage.sv
module scfr_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    scfr_byte_if.sink           i_rx,
    input  logic                i_take,
    output scfr_pkg::t_byte_beat o_beat
);

    logic       r_valid;
    logic [7:0] r_byte;

    // room when empty or when the held beat is consumed this cycle
    assign i_rx.ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    // byte payload
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_beat.valid   = r_valid;
    assign o_beat.rx_byte = r_byte;

endmodule

>>> rtl/core/scfr_deframer.sv
module scfr_deframer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scfr_pkg::t_byte_beat i_beat,
    input  logic                 i_out_free,
    output logic                 o_take,
    output scfr_pkg::t_cmd_beat  o_res
);

    scfr_pkg::t_frame_pos r_pos;
    scfr_pkg::t_frame_pos n_pos;
    logic [7:0]           r_prev;
    logic [7:0]           n_prev;
    logic [15:0]          r_sum;
    logic [15:0]          n_sum;
    logic [15:0]          r_cmd;
    logic [15:0]          n_cmd;
    logic [7:0]           r_csum_hi;
    logic [7:0]           n_csum_hi;
    logic                 sync_hit;
    logic                 csum_ok;
    logic [7:0]           b;

    assign b      = i_beat.rx_byte;
    assign o_take = i_beat.valid && i_out_free;

    assign sync_hit = (r_prev == scfr_pkg::SYNC_FIRST) && (b == scfr_pkg::SYNC_SECOND);
    assign csum_ok  = ({r_csum_hi, b} == r_sum);

    // next frame position
    always_comb begin
        n_pos = scfr_pkg::POS_HUNT;
        unique case (r_pos)
            scfr_pkg::POS_CMD_HI:  n_pos = scfr_pkg::POS_CMD_LO;
            scfr_pkg::POS_CMD_LO:  n_pos = scfr_pkg::POS_CSUM_HI;
            scfr_pkg::POS_CSUM_HI: n_pos = scfr_pkg::POS_CSUM_LO;
            scfr_pkg::POS_CSUM_LO: n_pos = scfr_pkg::POS_HUNT;
            default:               n_pos = sync_hit ? scfr_pkg::POS_CMD_HI
                                                    : scfr_pkg::POS_HUNT;
        endcase
    end

    // datapath updates and result
    always_comb begin
        n_prev        = r_prev;
        n_sum         = r_sum;
        n_cmd         = r_cmd;
        n_csum_hi     = r_csum_hi;
        o_res.valid   = 1'b0;
        o_res.command = r_cmd;
        unique case (r_pos)
            scfr_pkg::POS_CMD_HI: begin
                n_cmd = {b, 8'h00};
                n_sum = r_sum + {8'h00, b};
            end
            scfr_pkg::POS_CMD_LO: begin
                n_cmd = {r_cmd[15:8], b};
                n_sum = r_sum + {8'h00, b};
            end
            scfr_pkg::POS_CSUM_HI: begin
                n_csum_hi = b;
            end
            scfr_pkg::POS_CSUM_LO: begin
                o_res.valid = o_take && csum_ok;
                n_prev      = scfr_pkg::SYNC_SECOND;
            end
            default: begin
                if (sync_hit) begin
                    n_sum = {8'h00, scfr_pkg::SYNC_FIRST} + {8'h00, scfr_pkg::SYNC_SECOND};
                end
                n_prev = b;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= scfr_pkg::POS_HUNT;
            r_prev <= 8'h00;
        end else if (o_take) begin
            r_pos  <= n_pos;
            r_prev <= n_prev;
        end
    end

    // frame payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_sum     <= n_sum;
            r_cmd     <= n_cmd;
            r_csum_hi <= n_csum_hi;
        end
    end

endmodule

>>> rtl/core/scfr_out_stage.sv
module scfr_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scfr_pkg::t_cmd_beat i_res,
    output logic                o_free,
    scfr_cmd_if.source          o_cmd
);

    logic        r_valid;
    logic [15:0] r_command;

    // free when empty or when the held beat leaves this cycle
    assign o_free = !r_valid || o_cmd.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res.valid;
        end
    end

    // command payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_res.valid) begin
            r_command <= i_res.command;
        end
    end

    assign o_cmd.valid   = r_valid;
    assign o_cmd.command = r_command;

endmodule

>>> tb/scfr_frame_checker.sv
`timescale 1ns / 1ps

module scfr_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [15:0] i_cmd,
    output int          o_mismatches,
    output int          o_pending
);

    // shadow deframer state
    logic [7:0]           prev_byte;
    scfr_pkg::t_frame_pos frame_pos;
    logic [15:0]          frame_sum;
    logic [15:0]          cmd_word;
    logic [7:0]           csum_hi;

    // commands still owed by the block, oldest first
    logic [15:0] expected_cmds[$];
    logic [15:0] oldest_cmd;
    int          mismatches = 0;

    // advance the shadow deframer by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [15:0] received;
        case (frame_pos)
            scfr_pkg::POS_CMD_HI: begin
                cmd_word  = {b, 8'h00};
                frame_sum = frame_sum + {8'h00, b};
                frame_pos = scfr_pkg::POS_CMD_LO;
            end
            scfr_pkg::POS_CMD_LO: begin
                cmd_word  = {cmd_word[15:8], b};
                frame_sum = frame_sum + {8'h00, b};
                frame_pos = scfr_pkg::POS_CSUM_HI;
            end
            scfr_pkg::POS_CSUM_HI: begin
                csum_hi   = b;
                frame_pos = scfr_pkg::POS_CSUM_LO;
            end
            scfr_pkg::POS_CSUM_LO: begin
                received = {csum_hi, b};
                if (received == frame_sum) begin
                    expected_cmds.push_back(cmd_word);
                end
                frame_pos = scfr_pkg::POS_HUNT;
                prev_byte = scfr_pkg::SYNC_SECOND;
            end
            default: begin
                // hunting: look for the sync pair across the last two bytes
                frame_pos = scfr_pkg::POS_HUNT;
                if (prev_byte == scfr_pkg::SYNC_FIRST && b == scfr_pkg::SYNC_SECOND) begin
                    frame_pos = scfr_pkg::POS_CMD_HI;
                    frame_sum = {8'h00, scfr_pkg::SYNC_FIRST}
                              + {8'h00, scfr_pkg::SYNC_SECOND};
                end
                prev_byte = b;
            end
        endcase
    endtask

    // compare command beats first, then feed the byte beat into the shadow model
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            prev_byte = 8'h00;
            frame_pos = scfr_pkg::POS_HUNT;
            frame_sum = 16'h0000;
            cmd_word  = 16'h0000;
            csum_hi   = 8'h00;
            expected_cmds.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: command beat with none expected, actual %h",
                             $time, i_cmd);
                    mismatches++;
                end else begin
                    oldest_cmd = expected_cmds.pop_front();
                    if (i_cmd !== oldest_cmd) begin
                        $display("%0t: command mismatch, expected %h, actual %h",
                                 $time, oldest_cmd, i_cmd);
                        mismatches++;
                    end
                end
            end
            if (i_rx_valid && i_rx_ready) begin
                deframe_byte(i_rx_byte);
            end
        end
        o_mismatches = mismatches;
        o_pending    = expected_cmds.size();
    end

endmodule

>>> tb/tb_sync_checksum_frame_receiver.sv
`timescale 1ns / 1ps

module tb_sync_checksum_frame_receiver;

    logic i_clk;
    logic i_rst_n;
    int   phase;
    int   send_idle_pct;
    int   mismatches;
    int   pending;

    // receiver hold-off state
    int   hold_left;
    bit   hold_done;

    // short directed stream: extreme commands, overlapping sync, lone byte
    // after a frame, sync bytes as command data with a bad checksum
    localparam logic [7:0] DIRECTED [26] = '{
        8'hA5, 8'h5A, 8'h00, 8'h00, 8'h00, 8'hFF,
        8'hA5, 8'hA5, 8'h5A, 8'hFF, 8'hFF, 8'h02, 8'hFD,
        8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'h00, 8'h00,
        8'hA5, 8'h5A, 8'h12, 8'h34, 8'h01, 8'h45
    };

    scfr_byte_if rx_if ();
    scfr_cmd_if  cmd_if ();

    sync_checksum_frame_receiver i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_cmd   (cmd_if)
    );

    scfr_frame_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (rx_if.valid),
        .i_rx_ready   (rx_if.ready),
        .i_rx_byte    (rx_if.rx_byte),
        .i_cmd_valid  (cmd_if.valid),
        .i_cmd_ready  (cmd_if.ready),
        .i_cmd        (cmd_if.command),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // command sink: random stalls per phase, one long hold-off when the
    // no-idle phase starts so the block backs up onto its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left > 0) begin
            cmd_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (phase == 2 && !hold_done) begin
            cmd_if.ready <= 1'b0;
            hold_left    <= 300;
            hold_done    <= 1'b1;
        end else begin
            case (phase)
                0:       cmd_if.ready <= ($urandom_range(99) >= 65);
                1:       cmd_if.ready <= ($urandom_range(99) >= 36);
                default: cmd_if.ready <= 1'b1;
            endcase
        end
    end

    // offer one byte, with random idle cycles ahead of it, until it is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
    endtask

    // byte biased toward the extremes and the sync values
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return scfr_pkg::SYNC_FIRST;
            3:       return scfr_pkg::SYNC_SECOND;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // full frame, with a correct or a corrupted checksum
    task automatic send_frame(input logic [15:0] cmd, input bit good);
        logic [15:0] csum;
        csum = {8'h00, scfr_pkg::SYNC_FIRST} + {8'h00, scfr_pkg::SYNC_SECOND}
             + {8'h00, cmd[15:8]} + {8'h00, cmd[7:0]};
        if (!good) begin
            csum = csum ^ 16'($urandom_range(1, 65535));
        end
        send_byte(scfr_pkg::SYNC_FIRST);
        send_byte(scfr_pkg::SYNC_SECOND);
        send_byte(cmd[15:8]);
        send_byte(cmd[7:0]);
        send_byte(csum[15:8]);
        send_byte(csum[7:0]);
    endtask

    // mostly well-formed frames, some truncated ones, some line noise
    task automatic send_random_traffic(input int total_bytes);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < total_bytes) begin
            pick = $urandom_range(99);
            n = $urandom_range(2);
            repeat (n) send_byte(pick_byte());
            sent += n;
            if (pick < 80) begin
                send_frame({pick_byte(), pick_byte()}, $urandom_range(99) < 80);
                sent += 6;
            end else if (pick < 90) begin
                // sync followed by a short tail; later bytes finish the frame
                n = $urandom_range(4);
                send_byte(scfr_pkg::SYNC_FIRST);
                send_byte(scfr_pkg::SYNC_SECOND);
                repeat (n) send_byte(pick_byte());
                sent += 2 + n;
            end else begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(pick_byte());
                sent += n;
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        i_rst_n       <= 1'b0;
        phase         <= 0;
        send_idle_pct = 36;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) send_byte(DIRECTED[k]);

        send_random_traffic(580);
        phase         <= 1;
        send_idle_pct = 65;
        send_random_traffic(580);
        phase         <= 2;
        send_idle_pct = 0;
        send_random_traffic(590);
        rx_if.valid <= 1'b0;

        // drain outstanding commands, then allow for the output latency
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0t: %0d mismatches, %0d commands never seen",
                     $time, mismatches, pending);
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sync_checksum_frame_receiver.f
rtl/core/scfr_pkg.sv
rtl/core/scfr_if.sv
rtl/core/scfr_in_stage.sv
rtl/core/scfr_deframer.sv
rtl/core/scfr_out_stage.sv
rtl/core/sync_checksum_frame_receiver.sv
tb/scfr_frame_checker.sv
tb/tb_sync_checksum_frame_receiver.sv
